### rtl/backlight_pulse_step_dimmer_core_defines.svh
// Assertion macros shared by the dimmer core RTL.
`ifndef BACKLIGHT_PULSE_STEP_DIMMER_CORE_DEFINES_SVH
`define BACKLIGHT_PULSE_STEP_DIMMER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clock, off during reset.
`define BPSD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on clock, off during reset.
`define BPSD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BPSD_ASSERT_IMP(lbl, ante, cons, msg)
`define BPSD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/bpsd_pkg.sv
// Shared constants, codes and controller/datapath interface types of the dimmer core.
package bpsd_pkg;

   localparam int STEPS       = 32;
   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int LEVEL_W    = 8;
   localparam int STEP_W     = 6;
   localparam int IDX_W      = 5;
   localparam int HOLD_W     = 12;
   localparam int CUR_W      = 7;
   localparam int REM_W      = 8;
   localparam int V_W        = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [HOLD_W-1:0] HOLD_OFF_US   = 12'd3000;
   localparam logic [HOLD_W-1:0] HOLD_WAKE_US  = 12'd3;
   localparam logic [HOLD_W-1:0] HOLD_PULSE_US = 12'd1;

   localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST      = 8'd30;
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST      = 8'd255;
   localparam logic [STEP_W-1:0]  DIMMING_STEP_RST   = 6'd1;
   localparam logic [STEP_W-1:0]  ENTRIES_IN_USE_RST = 6'd23;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_LEVEL      = 2'd0,
      CSR_MAX_LEVEL      = 2'd1,
      CSR_DIMMING_STEP   = 2'd2,
      CSR_ENTRIES_IN_USE = 2'd3
   } csr_idx_type;

   typedef enum logic {
      REQ_LEVEL = 1'b0,
      REQ_ENTRY = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      TGT_ZERO = 2'd0,
      TGT_DIM  = 2'd1,
      TGT_MEM  = 2'd2
   } tgt_src_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] threshold;
      logic [STEP_W-1:0]  step;
   } entry_type;

   typedef struct packed {
      logic        capture;
      logic        tbl_wr;
      logic        walk_start;
      logic        last_read;
      logic        walk_next;
      logic        set_tgt;
      tgt_src_type tgt_src;
      logic        plan;
      logic        reduce;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic lvl_zero;
      logic lvl_dim;
      logic lvl_max;
      logic count_zero;
      logic hit;
      logic walk_end;
      logic rem_big;
      logic pend;
      logic out_free;
      logic emit_last;
   } sts_type;

endpackage

### rtl/backlight_pulse_step_dimmer_core.sv
// Top level of the pulse-count backlight dimmer: sequencer, datapath and checks.
// Table entry write: taken while idle, no result; the next request follows at once.
// Brightness request: taken, classified, then walked through the table one entry per cycle
// (at most the 32 entries of the table), or given a last-entry read, or neither when the level
// is zero or below the minimum or no entries are in use; then planned, the pulse count folded,
// and one line action per cycle (possibly none) loaded into the result register unless stalled.
// Reset (synchronous): configuration registers to their defaults, current step unknown; table undefined.
`include "backlight_pulse_step_dimmer_core_defines.svh"

module backlight_pulse_step_dimmer_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [bpsd_pkg::LEVEL_W-1:0]        req_level,
   input  logic                                req_line_sensed_high,
   input  logic [bpsd_pkg::IDX_W-1:0]          req_entry_index,
   input  logic [bpsd_pkg::LEVEL_W-1:0]        req_entry_threshold,
   input  logic [bpsd_pkg::STEP_W-1:0]         req_entry_step,
   // line action channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_line_level,
   output logic [bpsd_pkg::HOLD_W-1:0]         rsp_hold_us,
   output logic [bpsd_pkg::STEP_W-1:0]         rsp_target_step,
   output logic                                rsp_last,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpsd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bpsd_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;

   // Registers take a write in any cycle; software writes them only while the block is idle (not enforced here).
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // Sequencer: hold off new requests until the current one has loaded its last action,
   // advance through the table walk one entry per cycle, then emit actions one at a time.
   bpsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: register file, entry table (one write, one registered read per cycle),
   // current step, pulse count and the result register that decouples the output side.
   bpsd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_wr               (csr_wr),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_level            (req_level),
      .req_line_sensed_high (req_line_sensed_high),
      .req_entry_index      (req_entry_index),
      .req_entry_threshold  (req_entry_threshold),
      .req_entry_step       (req_entry_step),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_line_level       (rsp_line_level),
      .rsp_hold_us          (rsp_hold_us),
      .rsp_target_step      (rsp_target_step),
      .rsp_last             (rsp_last)
   );

   // Never load an action over one that is still waiting to be taken.
   `BPSD_ASSERT_IMP(a_emit_into_free, cmd.emit, sts.out_free, "action loaded over a waiting one")
   // A loaded action shows on the output in the next cycle.
   `BPSD_ASSERT_NXT(a_emit_shows, cmd.emit, rsp_valid, "loaded action not presented")
   // A brightness request occupies the sequencer after it is taken.
   `BPSD_ASSERT_NXT(a_level_busy, req_valid && !req_stall && req_type == REQ_LEVEL, req_stall, "request taken but sequencer idle")
   // At most one table read source per cycle.
   `BPSD_ASSERT_IMP(a_one_read, 1'b1, $onehot0({cmd.walk_start, cmd.last_read, cmd.walk_next}), "conflicting table reads")

endmodule

### rtl/bpsd_ctrl.sv
// Sequencer of the dimmer core: step choice, pulse planning and action emission.
module bpsd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_type,
   output logic              req_stall,
   input  bpsd_pkg::sts_type sts,
   output bpsd_pkg::cmd_type cmd
);
   import bpsd_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CLASSIFY = 7'b0000010,
      ST_LASTRD   = 7'b0000100,
      ST_WALK     = 7'b0001000,
      ST_PLAN     = 7'b0010000,
      ST_REDUCE   = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.tgt_src = TGT_ZERO;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_type == REQ_ENTRY) begin
                  cmd.tbl_wr = 1'b1;
               end else begin
                  state_in = ST_CLASSIFY;
               end
            end
         end
         ST_CLASSIFY: begin
            if (sts.lvl_zero) begin
               cmd.set_tgt = 1'b1;
               cmd.tgt_src = TGT_ZERO;
               state_in    = ST_PLAN;
            end else if (sts.lvl_dim) begin
               cmd.set_tgt = 1'b1;
               cmd.tgt_src = TGT_DIM;
               state_in    = ST_PLAN;
            end else if (sts.count_zero) begin
               cmd.set_tgt = 1'b1;
               cmd.tgt_src = TGT_ZERO;
               state_in    = ST_PLAN;
            end else if (sts.lvl_max) begin
               cmd.last_read = 1'b1;
               state_in      = ST_LASTRD;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_LASTRD: begin
            cmd.set_tgt = 1'b1;
            cmd.tgt_src = TGT_MEM;
            state_in    = ST_PLAN;
         end
         ST_WALK: begin
            if (sts.hit) begin
               cmd.set_tgt = 1'b1;
               cmd.tgt_src = TGT_MEM;
               state_in    = ST_PLAN;
            end else if (sts.walk_end) begin
               cmd.set_tgt = 1'b1;
               cmd.tgt_src = TGT_ZERO;
               state_in    = ST_PLAN;
            end else begin
               cmd.walk_next = 1'b1;
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (sts.rem_big) begin
               cmd.reduce = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!sts.pend) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/bpsd_dp.sv
// Datapath of the dimmer core: registers, entry table, step choice, pulse count, result register.
module bpsd_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  bpsd_pkg::cmd_type                   cmd,
   output bpsd_pkg::sts_type                   sts,
   input  logic                                csr_wr,
   input  logic [bpsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpsd_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [bpsd_pkg::LEVEL_W-1:0]        req_level,
   input  logic                                req_line_sensed_high,
   input  logic [bpsd_pkg::IDX_W-1:0]          req_entry_index,
   input  logic [bpsd_pkg::LEVEL_W-1:0]        req_entry_threshold,
   input  logic [bpsd_pkg::STEP_W-1:0]         req_entry_step,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_line_level,
   output logic [bpsd_pkg::HOLD_W-1:0]         rsp_hold_us,
   output logic [bpsd_pkg::STEP_W-1:0]         rsp_target_step,
   output logic                                rsp_last
);
   import bpsd_pkg::*;

   // configuration
   logic [LEVEL_W-1:0] min_level_ff, min_level_in;
   logic [LEVEL_W-1:0] max_level_ff, max_level_in;
   logic [STEP_W-1:0]  dimming_step_ff, dimming_step_in;
   logic [STEP_W-1:0]  entries_in_use_ff, entries_in_use_in;

   // request in flight
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               sensed_ff, sensed_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [STEP_W-1:0]  tgt_ff, tgt_in;
   logic [CUR_W-1:0]   cur_ff, cur_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               reset_pend_ff, reset_pend_in;
   logic               wake_pend_ff, wake_pend_in;
   logic               phase_ff, phase_in;

   // entry table
   entry_type          mem [TABLE_DEPTH];
   entry_type          rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_line_level_ff, rsp_line_level_in;
   logic [HOLD_W-1:0]  rsp_hold_us_ff, rsp_hold_us_in;
   logic [STEP_W-1:0]  rsp_target_step_ff, rsp_target_step_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]   count;
   logic [CNT_W-1:0]   idx_next;
   logic               unknown_high;
   logic [CUR_W-1:0]   cur1;
   logic               wake;
   logic [V_W-1:0]     cur_x;
   logic [V_W-1:0]     tgt_x;
   logic [V_W-1:0]     v;
   logic               out_free;
   logic               emit_last;

   // clamp the entry count to the table depth
   assign count    = (32'(entries_in_use_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(entries_in_use_ff);
   assign idx_next = idx_ff + CNT_W'(1);

   always_comb begin
      rd_en   = cmd.walk_start | cmd.last_read | cmd.walk_next;
      rd_addr = '0;
      if (cmd.last_read) begin
         rd_addr = ADDR_W'(count - CNT_W'(1));
      end else if (cmd.walk_next) begin
         rd_addr = idx_next[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_wr && (32'(req_entry_index) < TABLE_DEPTH)) begin
         mem[ADDR_W'(req_entry_index)] <= '{threshold: req_entry_threshold,
                                            step: req_entry_step};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // pulse planning from the current step
   assign unknown_high = cur_ff[CUR_W-1] & sensed_ff;
   assign cur1         = unknown_high ? '0 : cur_ff;
   assign wake         = (cur1 == '0);
   assign cur_x        = wake ? V_W'(STEPS) : {{(V_W-CUR_W){cur1[CUR_W-1]}}, cur1};
   assign tgt_x        = {{(V_W-STEP_W){1'b0}}, tgt_ff};
   assign v            = cur_x - tgt_x + V_W'(STEPS);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   always_comb begin
      if (reset_pend_ff) begin
         emit_last = !wake_pend_ff && (rem_ff == '0);
      end else if (wake_pend_ff) begin
         emit_last = (rem_ff == '0);
      end else begin
         emit_last = phase_ff && (rem_ff == REM_W'(1));
      end
   end

   always_comb begin
      sts.lvl_zero   = (level_ff == '0);
      sts.lvl_dim    = (level_ff < min_level_ff);
      sts.lvl_max    = (level_ff == max_level_ff);
      sts.count_zero = (count == '0);
      sts.hit        = (level_ff <= rd_data_ff.threshold);
      sts.walk_end   = (idx_next == count);
      sts.rem_big    = (rem_ff >= REM_W'(STEPS));
      sts.pend       = reset_pend_ff | wake_pend_ff | (rem_ff != '0);
      sts.out_free   = out_free;
      sts.emit_last  = emit_last;
   end

   always_comb begin
      min_level_in      = min_level_ff;
      max_level_in      = max_level_ff;
      dimming_step_in   = dimming_step_ff;
      entries_in_use_in = entries_in_use_ff;
      if (csr_wr) begin
         case (csr_idx_type'(csr_index))
            CSR_MIN_LEVEL:      min_level_in      = csr_data;
            CSR_MAX_LEVEL:      max_level_in      = csr_data;
            CSR_DIMMING_STEP:   dimming_step_in   = csr_data[STEP_W-1:0];
            CSR_ENTRIES_IN_USE: entries_in_use_in = csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      level_in      = level_ff;
      sensed_in     = sensed_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      reset_pend_in = reset_pend_ff;
      wake_pend_in  = wake_pend_ff;
      phase_in      = phase_ff;

      rsp_valid_in       = rsp_valid_ff & rsp_stall;
      rsp_line_level_in  = rsp_line_level_ff;
      rsp_hold_us_in     = rsp_hold_us_ff;
      rsp_target_step_in = rsp_target_step_ff;
      rsp_last_in        = rsp_last_ff;

      if (cmd.capture) begin
         level_in  = req_level;
         sensed_in = req_line_sensed_high;
      end
      if (cmd.walk_start) begin
         idx_in = '0;
      end
      if (cmd.walk_next) begin
         idx_in = idx_next;
      end
      if (cmd.set_tgt) begin
         case (cmd.tgt_src)
            TGT_ZERO: tgt_in = '0;
            TGT_DIM:  tgt_in = dimming_step_ff;
            TGT_MEM:  tgt_in = rd_data_ff.step;
            default:  tgt_in = '0;
         endcase
      end
      if (cmd.plan) begin
         phase_in = 1'b0;
         cur_in   = {{(CUR_W-STEP_W){1'b0}}, tgt_ff};
         if (tgt_ff == '0) begin
            // off: one long low hold
            reset_pend_in = 1'b1;
            wake_pend_in  = 1'b0;
            rem_in        = '0;
         end else begin
            reset_pend_in = unknown_high;
            wake_pend_in  = wake;
            rem_in        = v[V_W-1] ? '0 : v[REM_W-1:0];
         end
      end
      if (cmd.reduce) begin
         rem_in = rem_ff - REM_W'(STEPS);
      end
      if (cmd.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_target_step_in = tgt_ff;
         rsp_last_in        = emit_last;
         if (reset_pend_ff) begin
            reset_pend_in     = 1'b0;
            rsp_line_level_in = 1'b0;
            rsp_hold_us_in    = HOLD_OFF_US;
         end else if (wake_pend_ff) begin
            wake_pend_in      = 1'b0;
            rsp_line_level_in = 1'b1;
            rsp_hold_us_in    = HOLD_WAKE_US;
         end else begin
            rsp_line_level_in = phase_ff;
            rsp_hold_us_in    = HOLD_PULSE_US;
            phase_in          = ~phase_ff;
            if (phase_ff) begin
               rem_in = rem_ff - REM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff      <= MIN_LEVEL_RST;
         max_level_ff      <= MAX_LEVEL_RST;
         dimming_step_ff   <= DIMMING_STEP_RST;
         entries_in_use_ff <= ENTRIES_IN_USE_RST;
         cur_ff            <= '1;
         rem_ff            <= '0;
         reset_pend_ff     <= 1'b0;
         wake_pend_ff      <= 1'b0;
         phase_ff          <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         min_level_ff      <= min_level_in;
         max_level_ff      <= max_level_in;
         dimming_step_ff   <= dimming_step_in;
         entries_in_use_ff <= entries_in_use_in;
         cur_ff            <= cur_in;
         rem_ff            <= rem_in;
         reset_pend_ff     <= reset_pend_in;
         wake_pend_ff      <= wake_pend_in;
         phase_ff          <= phase_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff           <= level_in;
      sensed_ff          <= sensed_in;
      idx_ff             <= idx_in;
      tgt_ff             <= tgt_in;
      rsp_line_level_ff  <= rsp_line_level_in;
      rsp_hold_us_ff     <= rsp_hold_us_in;
      rsp_target_step_ff <= rsp_target_step_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_level  = rsp_line_level_ff;
   assign rsp_hold_us     = rsp_hold_us_ff;
   assign rsp_target_step = rsp_target_step_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
